/* hdl/scanning_range_to_cartesian_top_macros.svh */
// ----------------------------------------------------------------------------
// scanning range to cartesian assertion macros
// shared concurrent checks, clocked on clk and disabled during reset
// ----------------------------------------------------------------------------
`ifndef SCANNING_RANGE_TO_CARTESIAN_TOP_MACROS_SVH
`define SCANNING_RANGE_TO_CARTESIAN_TOP_MACROS_SVH

// condition holds in the same cycle as the trigger
`define SRC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// condition holds in the cycle after the trigger
`define SRC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

/* hdl/src_pkg.sv */
// ----------------------------------------------------------------------------
// src_pkg
// constants, fixed-point helpers and angle tables for range to point conversion
// ----------------------------------------------------------------------------
package src_pkg;

	localparam int PIX_ROWS = 512;
	localparam int PIX_COLS = 512;
	localparam int ROW_AW = (PIX_ROWS > 1) ? $clog2(PIX_ROWS) : 1;
	localparam int COL_AW = (PIX_COLS > 1) ? $clog2(PIX_COLS) : 1;

	// configuration register indexes
	localparam logic [7:0] REG_STANDOFF = 8'd0;
	localparam logic [7:0] REG_UNIT     = 8'd1;

	localparam logic [26:0] STANDOFF_RESET = 27'd54414541;
	localparam logic [15:0] UNIT_RESET     = 16'd13262;

	// 5.5 in q30
	localparam logic signed [34:0] H2_Q30 = 35'sd5905580032;

	// table build constants, angles in q60
	localparam logic signed [63:0] Q60_ONE     = 64'sd1 <<< 60;
	localparam logic signed [63:0] PI_Q60      = 64'sh3243F6A8885A308D;
	localparam logic signed [63:0] ANGLE_DEN   = 64'sd18432000;
	localparam logic signed [63:0] H_FOV_CDEG  = 64'sd5165;
	localparam logic signed [63:0] V_FOV_CDEG  = 64'sd3673;
	localparam logic signed [63:0] CENTER_TWICE = 64'sd511;

	typedef enum logic [2:0] {
		TK_SIN,
		TK_COS,
		TK_TAN,
		TK_SEC,
		TK_DZ
	} tab_kind_t;

	typedef logic signed [31:0] col_tab_t [PIX_COLS];
	typedef logic signed [31:0] row_tab_t [PIX_ROWS];

	// truncated signed q60 product
	function automatic logic signed [63:0] mul_q60(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic [127:0] ua;
		logic [127:0] ub;
		logic [127:0] p;
		logic [63:0] m;
		ua = {64'd0, (a[63] ? 64'(-a) : 64'(a))};
		ub = {64'd0, (b[63] ? 64'(-b) : 64'(b))};
		p = ua * ub;
		m = p[123:60];
		return (a[63] ^ b[63]) ? -$signed(m) : $signed(m);
	endfunction

	// q60 to q30 rounded half away from zero
	function automatic logic signed [31:0] round_q30(input logic signed [63:0] v);
		logic [63:0] m;
		m = v[63] ? 64'(-v) : 64'(v);
		m = (m + 64'd536870912) >> 30;
		return v[63] ? -$signed(m[31:0]) : $signed(m[31:0]);
	endfunction

	// quotient in q30 by restoring long division, rounded half away from zero
	function automatic logic signed [31:0] div_q30(input logic signed [63:0] n,
		input logic signed [63:0] d);
		logic [127:0] num;
		logic [127:0] ud;
		logic [127:0] r;
		logic [127:0] q;
		num = {33'd0, (n[63] ? 64'(-n) : 64'(n)), 31'd0};
		ud = (d > 0) ? {64'd0, 64'(d)} : 128'd1;
		r = '0;
		q = '0;
		for (int i = 127; i >= 0; i--) begin
			r = {r[126:0], num[i]};
			q = {q[126:0], 1'b0};
			if (r >= ud) begin
				r = r - ud;
				q[0] = 1'b1;
			end
		end
		q = (q + 128'd1) >> 1;
		return n[63] ? -$signed(q[31:0]) : $signed(q[31:0]);
	endfunction

	function automatic logic signed [63:0] angle_step(input logic signed [63:0] num);
		return (PI_Q60 / ANGLE_DEN) * num + ((PI_Q60 % ANGLE_DEN) * num) / ANGLE_DEN;
	endfunction

	// taylor series sine, 14 terms
	function automatic logic signed [63:0] sin_q60(input logic signed [63:0] x);
		logic signed [63:0] x2;
		logic signed [63:0] t;
		logic signed [63:0] s;
		x2 = mul_q60(x, x);
		t = x;
		s = x;
		for (int k = 1; k <= 13; k++) begin
			t = -mul_q60(t, x2) / 64'(((2 * k) * (2 * k + 1)));
			s = s + t;
		end
		return s;
	endfunction

	// taylor series cosine, 14 terms
	function automatic logic signed [63:0] cos_q60(input logic signed [63:0] x);
		logic signed [63:0] x2;
		logic signed [63:0] t;
		logic signed [63:0] s;
		x2 = mul_q60(x, x);
		t = Q60_ONE;
		s = Q60_ONE;
		for (int k = 1; k <= 13; k++) begin
			t = -mul_q60(t, x2) / 64'(((2 * k - 1) * (2 * k)));
			s = s + t;
		end
		return s;
	endfunction

	// per-column tables of alpha
	function automatic col_tab_t col_table(input tab_kind_t kind);
		col_tab_t tab;
		logic signed [63:0] a;
		logic signed [63:0] sn;
		logic signed [63:0] cs;
		for (int i = 0; i < PIX_COLS; i++) begin
			a = angle_step(H_FOV_CDEG) * (CENTER_TWICE - 64'(2 * i));
			sn = sin_q60(a);
			cs = cos_q60(a);
			case (kind)
				TK_SIN:  tab[i] = round_q30(sn);
				TK_COS:  tab[i] = round_q30(cs);
				TK_TAN:  tab[i] = div_q30(sn, cs);
				TK_SEC:  tab[i] = div_q30(Q60_ONE, cs);
				TK_DZ:   tab[i] = round_q30(-64'sd3 * (Q60_ONE - cs));
				default: tab[i] = '0;
			endcase
		end
		return tab;
	endfunction

	// per-row tables of beta, tan uses the half angle plus 45 deg
	function automatic row_tab_t row_table(input tab_kind_t kind);
		row_tab_t tab;
		logic signed [63:0] b;
		logic signed [63:0] h;
		for (int i = 0; i < PIX_ROWS; i++) begin
			b = angle_step(V_FOV_CDEG) * (CENTER_TWICE - 64'(2 * i));
			h = PI_Q60 / 64'sd4 + b / 64'sd2;
			case (kind)
				TK_SIN:  tab[i] = round_q30(sin_q60(b));
				TK_COS:  tab[i] = round_q30(cos_q60(b));
				TK_TAN:  tab[i] = div_q30(sin_q60(h), cos_q60(h));
				default: tab[i] = '0;
			endcase
		end
		return tab;
	endfunction

	localparam col_tab_t COL_SIN = col_table(TK_SIN);
	localparam col_tab_t COL_COS = col_table(TK_COS);
	localparam col_tab_t COL_TAN = col_table(TK_TAN);
	localparam col_tab_t COL_SEC = col_table(TK_SEC);
	localparam col_tab_t COL_DZ  = col_table(TK_DZ);
	localparam row_tab_t ROW_SIN = row_table(TK_SIN);
	localparam row_tab_t ROW_COS = row_table(TK_COS);
	localparam row_tab_t ROW_TNH = row_table(TK_TAN);

	// signed product back to q30, rounded half away from zero
	function automatic logic signed [79:0] rnd_q30(input logic signed [79:0] p);
		logic signed [79:0] bias;
		bias = p[79] ? 80'sd536870911 : 80'sd536870912;
		return (p + bias) >>> 30;
	endfunction

endpackage

/* hdl/scanning_range_to_cartesian_top.sv */
// ----------------------------------------------------------------------------
// scanning_range_to_cartesian_top
// range pixel to q16.16 point for a two-mirror scanning laser camera
// ----------------------------------------------------------------------------
// Usage:
// - input stream s_*: one pixel per transfer, row, column and raw range count
// - output stream m_*: x, y, z in signed q16.16, saturated, one per pixel
// - config channel cfg_*: index 0 standoff (q11.16), index 1 range unit (q0.16);
//   always ready, write only while no pixel is in flight
// - throughput: one pixel per cycle while not stalled; the nine register stages
//   (angle table reads, angle products, offset sum, two products, range sum,
//   split products, product merge, final sum, output rounding) each hold one pixel
// - valid path: an input transfer sets v_s1, moves through v_s2 to v_s8, then sets m_tvalid
// - reset: pipeline emptied, registers back to 830.3 and 0.20236
// - stall: when m_tvalid is high and m_tready low every stage holds and
//   s_tready drops in the same cycle; nothing is dropped or repeated
// ----------------------------------------------------------------------------
`include "scanning_range_to_cartesian_top_macros.svh"

module scanning_range_to_cartesian_top
	import src_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // pixel_row[8:0], pixel_col[17:9], range_value[29:18]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata,   // x_coord[31:0], y_coord[63:32], z_coord[95:64]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [26:0] cfg_data
);

	logic [26:0] standoff_q;
	logic [15:0] unit_q;
	logic        en;

	logic [8:0]        pixel_row;
	logic [8:0]        pixel_col;
	logic [11:0]       range_value;
	logic [ROW_AW-1:0] row_idx;
	logic [COL_AW-1:0] col_idx;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;

	// config registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			standoff_q <= STANDOFF_RESET;
			unit_q <= UNIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_STANDOFF: standoff_q <= cfg_data;
				REG_UNIT:     unit_q <= cfg_data[15:0];
				default:      ;
			endcase
		end
	end

	// whole pipe advances unless the output holds a result not taken
	assign en = !m_tvalid || m_tready;
	assign s_tready = en;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, m_tvalid} <= '0;
		end else if (en) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, m_tvalid} <=
				{s_tvalid, v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8};
		end
	end

	// input unpack and index clamp
	assign pixel_row = s_tdata[8:0];
	assign pixel_col = s_tdata[17:9];
	assign range_value = s_tdata[29:18];
	assign row_idx = (pixel_row > 9'(PIX_ROWS - 1)) ? ROW_AW'(PIX_ROWS - 1)
		: ROW_AW'(pixel_row);
	assign col_idx = (pixel_col > 9'(PIX_COLS - 1)) ? COL_AW'(PIX_COLS - 1)
		: COL_AW'(pixel_col);

	// stage 1: table reads, raw range plus standoff
	logic signed [31:0] dz_s1, tnh_s1, tan_s1, sec_s1, sina_s1, cosa_s1, sinb_s1, cosb_s1;
	logic [28:0]        base_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			dz_s1 <= COL_DZ[col_idx];
			tan_s1 <= COL_TAN[col_idx];
			sec_s1 <= COL_SEC[col_idx];
			sina_s1 <= COL_SIN[col_idx];
			cosa_s1 <= COL_COS[col_idx];
			tnh_s1 <= ROW_TNH[row_idx];
			sinb_s1 <= ROW_SIN[row_idx];
			cosb_s1 <= ROW_COS[row_idx];
			base_s1 <= {1'b0, range_value, 16'd0} + {2'b00, standoff_q};
		end
	end

	// stage 2: dy, combined angle factors, scaled range
	logic signed [63:0] p_dy, p_cs, p_cc;
	logic signed [32:0] dy_s2;
	logic signed [31:0] cs_s2, cc_s2, dz_s2, tan_s2, sec_s2, sina_s2;
	logic [45:0]        tprod_s2;
	logic signed [79:0] r_dy, r_cs, r_cc;

	assign p_dy = dz_s1 * tnh_s1;
	assign p_cs = cosa_s1 * sinb_s1;
	assign p_cc = cosa_s1 * cosb_s1;
	assign r_dy = rnd_q30({{16{p_dy[63]}}, p_dy});
	assign r_cs = rnd_q30({{16{p_cs[63]}}, p_cs});
	assign r_cc = rnd_q30({{16{p_cc[63]}}, p_cc});

	always_ff @(posedge clk) begin
		if (en) begin
			dy_s2 <= r_dy[32:0];
			cs_s2 <= r_cs[31:0];
			cc_s2 <= r_cc[31:0];
			tprod_s2 <= 46'(base_s1 * unit_q);
			dz_s2 <= dz_s1;
			tan_s2 <= tan_s1;
			sec_s2 <= sec_s1;
			sina_s2 <= sina_s1;
		end
	end

	// stage 3: 5.5 + dy and its magnitude, range term to q30
	logic signed [34:0] hq;
	logic signed [34:0] hq_s3;
	logic signed [35:0] habs_s3;
	logic [43:0]        t30_s3;
	logic signed [32:0] dy_s3;
	logic signed [31:0] dz_s3, tan_s3, sec_s3, sina_s3, cs_s3, cc_s3;
	logic [45:0]        t_rnd;

	assign hq = H2_Q30 + 35'(dy_s2);
	assign t_rnd = tprod_s2 + 46'd2;

	always_ff @(posedge clk) begin
		if (en) begin
			hq_s3 <= hq;
			habs_s3 <= hq[34] ? -36'(hq) : 36'(hq);
			t30_s3 <= t_rnd[45:2];
			dy_s3 <= dy_s2;
			dz_s3 <= dz_s2;
			tan_s3 <= tan_s2;
			sec_s3 <= sec_s2;
			sina_s3 <= sina_s2;
			cs_s3 <= cs_s2;
			cc_s3 <= cc_s2;
		end
	end

	// stage 4: dx and slant length of the mirror offset
	logic signed [66:0] p_dx;
	logic signed [67:0] p_hs;
	logic signed [79:0] r_dx, r_hs;
	logic signed [36:0] dx_s4;
	logic signed [37:0] hs_s4;
	logic [43:0]        t30_s4;
	logic signed [32:0] dy_s4;
	logic signed [31:0] dz_s4, sina_s4, cs_s4, cc_s4;

	assign p_dx = hq_s3 * tan_s3;
	assign p_hs = habs_s3 * sec_s3;
	assign r_dx = rnd_q30({{13{p_dx[66]}}, p_dx});
	assign r_hs = rnd_q30({{12{p_hs[67]}}, p_hs});

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s4 <= r_dx[36:0];
			hs_s4 <= r_hs[37:0];
			t30_s4 <= t30_s3;
			dy_s4 <= dy_s3;
			dz_s4 <= dz_s3;
			sina_s4 <= sina_s3;
			cs_s4 <= cs_s3;
			cc_s4 <= cc_s3;
		end
	end

	// stage 5: r3 = range term - (dz - 5.5) - slant
	logic signed [45:0] r3_s5;
	logic signed [36:0] dx_s5;
	logic signed [32:0] dy_s5;
	logic signed [31:0] dz_s5, sina_s5, cs_s5, cc_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			r3_s5 <= $signed({2'b00, t30_s4}) - 46'(dz_s4) + 46'(H2_Q30) - 46'(hs_s4);
			dx_s5 <= dx_s4;
			dy_s5 <= dy_s4;
			dz_s5 <= dz_s4;
			sina_s5 <= sina_s4;
			cs_s5 <= cs_s4;
			cc_s5 <= cc_s4;
		end
	end

	// stage 6: r3 split in two halves, six partial products
	logic signed [22:0] r3_hi;
	logic signed [23:0] r3_lo;
	logic signed [54:0] phx_s6, phy_s6, phz_s6;
	logic signed [55:0] plx_s6, ply_s6, plz_s6;
	logic signed [36:0] dx_s6;
	logic signed [32:0] dy_s6;
	logic signed [31:0] dz_s6;

	assign r3_hi = r3_s5[45:23];
	assign r3_lo = $signed({1'b0, r3_s5[22:0]});

	always_ff @(posedge clk) begin
		if (en) begin
			phx_s6 <= r3_hi * sina_s5;
			phy_s6 <= r3_hi * cs_s5;
			phz_s6 <= r3_hi * cc_s5;
			plx_s6 <= r3_lo * sina_s5;
			ply_s6 <= r3_lo * cs_s5;
			plz_s6 <= r3_lo * cc_s5;
			dx_s6 <= dx_s5;
			dy_s6 <= dy_s5;
			dz_s6 <= dz_s5;
		end
	end

	// stage 7: merge partial products
	logic signed [79:0] px_s7, py_s7, pz_s7;
	logic signed [36:0] dx_s7;
	logic signed [32:0] dy_s7;
	logic signed [31:0] dz_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			px_s7 <= (80'(phx_s6) <<< 23) + 80'(plx_s6);
			py_s7 <= (80'(phy_s6) <<< 23) + 80'(ply_s6);
			pz_s7 <= (80'(phz_s6) <<< 23) + 80'(plz_s6);
			dx_s7 <= dx_s6;
			dy_s7 <= dy_s6;
			dz_s7 <= dz_s6;
		end
	end

	// stage 8: round products and add offsets, q30 coordinates
	logic signed [79:0] rx, ry, rz;
	logic signed [49:0] x30_s8, y30_s8, z30_s8;

	assign rx = rnd_q30(px_s7);
	assign ry = rnd_q30(py_s7);
	assign rz = rnd_q30(pz_s7);

	always_ff @(posedge clk) begin
		if (en) begin
			x30_s8 <= rx[49:0] + 50'(dx_s7);
			y30_s8 <= ry[49:0] + 50'(dy_s7);
			z30_s8 <= rz[49:0] + 50'(dz_s7);
		end
	end

	// output register: q30 to q16.16 with rounding and saturation
	function automatic logic [31:0] to_q16(input logic signed [49:0] v);
		logic signed [49:0] bias;
		logic signed [49:0] r;
		bias = v[49] ? 50'sd8191 : 50'sd8192;
		r = (v + bias) >>> 14;
		if (r > 50'sd2147483647) begin
			return 32'h7FFFFFFF;
		end else if (r < -50'sd2147483648) begin
			return 32'h80000000;
		end
		return r[31:0];
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= {to_q16(z30_s8), to_q16(y30_s8), to_q16(x30_s8)};
		end
	end

	// checks
	`SRC_ASSERT_NOW(a_stall_blocks_input, m_tvalid && !m_tready, !s_tready)
	`SRC_ASSERT_NEXT(a_input_enters_pipe, s_tvalid && s_tready, v_s1)
	`SRC_ASSERT_NEXT(a_last_stage_reaches_out, v_s8 && s_tready, m_tvalid)

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// checks the range pixel to cartesian point stream against a bit-exact
// predictor with its own angle tables, under random stalls on both streams,
// a long output hold-off and several standoff and unit settings
// ----------------------------------------------------------------------------
module tb;
	import src_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint ONE_Q60 = 64'sd1 <<< 60;
	localparam longint PI_Q60_TB = 64'sh3243F6A8885A308D;
	localparam longint ANG_DEN = 64'sd18432000;
	localparam longint MIRROR_OFS_Q30 = 64'sd5905580032;
	localparam logic [7:0] REG_UNUSED = 8'd2;
	localparam logic [7:0] REG_TOP = 8'd255;
	localparam int DRAIN_CYCLES = 20;

	typedef struct packed {
		logic signed [31:0] z;
		logic signed [31:0] y;
		logic signed [31:0] x;
	} point_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [31:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [95:0] m_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [7:0] cfg_index = '0;
	logic [26:0] cfg_data = '0;

	// angle tables, q2.30
	longint alpha_sin[PIX_COLS], alpha_cos[PIX_COLS], alpha_tan[PIX_COLS];
	longint alpha_sec[PIX_COLS], alpha_dz[PIX_COLS];
	longint beta_sin[PIX_ROWS], beta_cos[PIX_ROWS], beta_tanh[PIX_ROWS];

	logic [26:0] standoff_cur;
	logic [15:0] unit_cur;
	point_t point_queue[$];
	int mismatches = 0;
	int hold_cycles = 0;
	int ready_wait = 0;
	bit no_idle = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	scanning_range_to_cartesian_top dut (.*);

	// signed (a*b) >> s with optional round half away from zero
	function automatic longint mul_shift(longint a, longint b, int s, bit rnd);
		logic [127:0] p;
		logic [63:0] ua, ub;
		bit neg;
		neg = (a < 0) != (b < 0);
		ua = (a < 0) ? 64'(-a) : 64'(a);
		ub = (b < 0) ? 64'(-b) : 64'(b);
		p = {64'd0, ua} * {64'd0, ub};
		if (rnd) p = p + (128'd1 << (s - 1));
		p = p >> s;
		return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
	endfunction

	function automatic longint round_sh(longint v, int s);
		logic [63:0] m;
		m = (v < 0) ? 64'(-v) : 64'(v);
		m = (m + (64'd1 << (s - 1))) >> s;
		return (v < 0) ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint quot_q30(longint n, longint d);
		logic [127:0] q;
		logic [63:0] un;
		un = (n < 0) ? 64'(-n) : 64'(n);
		q = ({64'd0, un} << 31) / {64'd0, 64'(d > 0 ? d : 1)};
		q = (q + 128'd1) >> 1;
		return (n < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
	endfunction

	task automatic taylor(input longint x, output longint sn, output longint cs);
		longint x2, ts, tc;
		x2 = mul_shift(x, x, 60, 1'b0);
		ts = x;
		tc = ONE_Q60;
		sn = x;
		cs = ONE_Q60;
		for (int k = 1; k <= 13; k++) begin
			ts = -mul_shift(ts, x2, 60, 1'b0) / longint'((2 * k) * (2 * k + 1));
			tc = -mul_shift(tc, x2, 60, 1'b0) / longint'((2 * k - 1) * (2 * k));
			sn += ts;
			cs += tc;
		end
	endtask

	function automatic longint step_q60(longint num);
		return (PI_Q60_TB / ANG_DEN) * num + ((PI_Q60_TB % ANG_DEN) * num) / ANG_DEN;
	endfunction

	task automatic build_angle_tables();
		longint ka, kb, a, sn, cs;
		ka = step_q60(5165);
		kb = step_q60(3673);
		for (int i = 0; i < PIX_COLS; i++) begin
			taylor(ka * (511 - 2 * i), sn, cs);
			alpha_sin[i] = round_sh(sn, 30);
			alpha_cos[i] = round_sh(cs, 30);
			alpha_tan[i] = quot_q30(sn, cs);
			alpha_sec[i] = quot_q30(ONE_Q60, cs);
			alpha_dz[i] = round_sh(-3 * (ONE_Q60 - cs), 30);
		end
		for (int i = 0; i < PIX_ROWS; i++) begin
			a = kb * (511 - 2 * i);
			taylor(a, sn, cs);
			beta_sin[i] = round_sh(sn, 30);
			beta_cos[i] = round_sh(cs, 30);
			taylor(PI_Q60_TB / 4 + a / 2, sn, cs);
			beta_tanh[i] = quot_q30(sn, cs);
		end
	endtask

	function automatic logic signed [31:0] sat_q16(longint v30);
		longint v;
		v = round_sh(v30, 14);
		if (v > 64'sd2147483647) v = 64'sd2147483647;
		if (v < -64'sd2147483648) v = -64'sd2147483648;
		return v[31:0];
	endfunction

	// expected point for one pixel under the current registers
	function automatic point_t pixel_to_point(int row, int col, int rng);
		longint dz, dy, hq, dx, t30, r3;
		point_t p;
		dz = alpha_dz[col];
		dy = mul_shift(dz, beta_tanh[row], 30, 1'b1);
		hq = MIRROR_OFS_Q30 + dy;
		dx = mul_shift(hq, alpha_tan[col], 30, 1'b1);
		t30 = round_sh(((longint'(rng) << 16) + longint'(standoff_cur)) * longint'(unit_cur), 2);
		r3 = t30 - (dz - MIRROR_OFS_Q30)
			- mul_shift(hq < 0 ? -hq : hq, alpha_sec[col], 30, 1'b1);
		p.x = sat_q16(dx + mul_shift(r3, alpha_sin[col], 30, 1'b1));
		p.y = sat_q16(dy + mul_shift(r3,
			mul_shift(alpha_cos[col], beta_sin[row], 30, 1'b1), 30, 1'b1));
		p.z = sat_q16(dz + mul_shift(r3,
			mul_shift(alpha_cos[col], beta_cos[row], 30, 1'b1), 30, 1'b1));
		return p;
	endfunction

	// output side: random stalls, long hold-off on request, result check
	always @(posedge clk) begin
		point_t got, want;
		if (m_tvalid && m_tready) begin
			got = m_tdata;
			if (point_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected point %h", m_tdata);
			end else begin
				want = point_queue.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("point mismatch: expected x %h y %h z %h, got x %h y %h z %h",
							want.x, want.y, want.z, got.x, got.y, got.z);
				end
			end
			ready_wait = no_idle ? 0 : $urandom_range(0, 3);
		end
		if (hold_cycles > 0) begin
			hold_cycles--;
			m_tready <= 1'b0;
		end else if (ready_wait > 0) begin
			ready_wait--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic send_pixel(input int row, input int col, input int rng);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {2'b00, rng[11:0], col[8:0], row[8:0]};
		do @(posedge clk); while (!s_tready);
		point_queue.push_back(pixel_to_point(row, col, rng));
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (point_queue.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [7:0] idx, input logic [26:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
		if (idx == REG_STANDOFF) standoff_cur = value;
		else if (idx == REG_UNIT) unit_cur = value[15:0];
	endtask

	task automatic set_regs(input logic [26:0] stand, input logic [15:0] unit);
		wait_idle();
		write_reg(REG_STANDOFF, stand);
		write_reg(REG_UNIT, {11'd0, unit});
	endtask

	// corners of the image and range, center and inner pixels, default registers
	task automatic test_directed();
		send_pixel(0, 0, 0);
		send_pixel(511, 511, 4095);
		send_pixel(0, 511, 4095);
		send_pixel(511, 0, 0);
		send_pixel(255, 256, 2048);
		send_pixel(256, 255, 1);
		send_pixel(255, 255, 4094);
		send_pixel(256, 256, 1365);
		send_pixel(170, 341, 2730);
		send_pixel(341, 170, 1365);
	endtask

	// register extremes, zero unit, ignored indexes
	task automatic test_registers();
		set_regs(27'h7FFFFFF, 16'hFFFF);
		send_pixel(0, 0, 4095);
		send_pixel(511, 511, 4095);
		send_pixel(255, 256, 4095);
		set_regs(27'd0, 16'd1);
		send_pixel(0, 511, 0);
		send_pixel(511, 0, 0);
		set_regs(27'd12345, 16'd0);
		send_pixel(100, 400, 4095);
		send_pixel(511, 511, 0);
		wait_idle();
		write_reg(REG_UNUSED, 27'h5555555);
		write_reg(REG_TOP, 27'h2AAAAAA);
		send_pixel(300, 50, 3000);
		send_pixel(0, 0, 0);
	endtask

	function automatic int pick_coord();
		case ($urandom_range(0, 7))
			0: return 0;
			1: return 511;
			default: return $urandom_range(0, 511);
		endcase
	endfunction

	// random pixels across several register settings, some without idling
	task automatic test_random();
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: set_regs(STANDOFF_RESET, UNIT_RESET);
				1: set_regs(27'h7FFFFFF, 16'hFFFF);
				2: set_regs(27'd0, 16'd1);
				default: set_regs(27'($urandom_range(0, 27'h7FFFFFF)),
					16'($urandom_range(1, 16'hFFFF)));
			endcase
			no_idle = (ph == 3);
			for (int i = 0; i < 200; i++)
				send_pixel(pick_coord(), pick_coord(), $urandom_range(0, 4095));
			no_idle = 1'b0;
		end
	endtask

	// long output hold-off while input keeps offering, fills the pipeline
	task automatic test_backpressure();
		wait_idle();
		hold_cycles = 60;
		no_idle = 1'b1;
		for (int i = 0; i < 100; i++)
			send_pixel(pick_coord(), pick_coord(), $urandom_range(0, 4095));
		no_idle = 1'b0;
	endtask

	initial begin
		build_angle_tables();
		standoff_cur = STANDOFF_RESET;
		unit_cur = UNIT_RESET;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_registers();
		test_backpressure();
		test_random();
		wait_idle();
		if (mismatches == 0 && point_queue.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin
		#2ms;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
